// ===== hw/rtl/scf_pkg.sv =====
// Shared types and constants for the speed command framer.
// Depends on nothing; scf_front, scf_queue, scf_back and speed_command_framer import it.
package scf_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] SPEED_CODE  = 8'h01;

    localparam int VALUE_BYTES = 4;
    localparam int VALUE_COUNT = 3;
    localparam int VALUE_W     = VALUE_COUNT * VALUE_BYTES * 8;

    // opening flag, id, code, value bytes, closing flag
    localparam int TOKENS  = VALUE_COUNT * VALUE_BYTES + 4;
    localparam int TOK_W   = $clog2(TOKENS);

    localparam logic [TOK_W-1:0] TOK_OPEN  = TOK_W'(0);
    localparam logic [TOK_W-1:0] TOK_ID    = TOK_W'(1);
    localparam logic [TOK_W-1:0] TOK_CODE  = TOK_W'(2);
    localparam logic [TOK_W-1:0] TOK_CLOSE = TOK_W'(TOKENS - 1);

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       esc;
        logic       last;
    } tok_t;

endpackage

// ===== hw/rtl/scf_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one speed command.
// Depends on nothing.
interface scf_cmd_if;

    logic        valid;
    logic        ready;
    logic [7:0]  robot_id;
    logic [31:0] speed_x_bits;
    logic [31:0] speed_y_bits;
    logic [31:0] turn_rate_bits;

    modport source (output valid, output robot_id, output speed_x_bits,
                    output speed_y_bits, output turn_rate_bits, input ready);
    modport sink   (input valid, input robot_id, input speed_x_bits,
                    input speed_y_bits, input turn_rate_bits, output ready);

endinterface

// ===== hw/rtl/scf_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one framed byte per beat.
// Depends on nothing.
interface scf_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;

    modport source (output valid, output out_byte, output is_last, input ready);
    modport sink   (input valid, input out_byte, input is_last, output ready);

endinterface

// ===== hw/rtl/scf_front.sv =====
// Front end: accepts a command and walks it into a stream of tokens,
// marking value bytes that need an escape. Depends on scf_pkg, scf_cmd_if.
module scf_front (
    input  logic          clk,
    input  logic          rst_n,
    scf_cmd_if.sink       cmd,
    output scf_pkg::tok_t tok,
    output logic          tok_valid,
    input  logic          tok_ready
);
    import scf_pkg::*;

    logic                busy_reg, busy_next;
    logic [TOK_W-1:0]    idx_reg, idx_next;
    logic [7:0]          id_reg, id_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                push;
    logic                at_close;
    logic                take;

    assign push      = busy_reg && tok_ready;
    assign at_close  = (idx_reg == TOK_CLOSE);
    assign cmd.ready = !busy_reg || (push && at_close);
    assign take      = cmd.valid && cmd.ready;
    assign tok_valid = busy_reg;

    always_comb
    begin
        tok.esc  = 1'b0;
        tok.last = 1'b0;
        case (idx_reg)
            TOK_OPEN:  tok.data = FLAG_BYTE;
            TOK_ID:    tok.data = id_reg;
            TOK_CODE:  tok.data = SPEED_CODE;
            TOK_CLOSE:
            begin
                tok.data = FLAG_BYTE;
                tok.last = 1'b1;
            end
            default:
            begin
                tok.data = val_reg[7:0];
                tok.esc  = (val_reg[7:0] == FLAG_BYTE) || (val_reg[7:0] == ESCAPE_BYTE);
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        id_next   = id_reg;
        val_next  = val_reg;
        if (push)
        begin
            idx_next = idx_reg + TOK_W'(1);
            // advance value bytes, least significant first
            if (idx_reg > TOK_CODE && !at_close)
            begin
                val_next = {8'h00, val_reg[VALUE_W-1:8]};
            end
            if (at_close)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = TOK_OPEN;
            id_next   = cmd.robot_id;
            val_next  = {cmd.turn_rate_bits, cmd.speed_y_bits, cmd.speed_x_bits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= TOK_OPEN;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        val_reg <= val_next;
    end

endmodule

// ===== hw/rtl/scf_queue.sv =====
// Short token queue between the front and back ends.
// Depends on scf_pkg.
module scf_queue #(
    parameter int Depth = scf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  scf_pkg::tok_t wr_tok,
    input  logic          wr_valid,
    output logic          wr_ready,
    output scf_pkg::tok_t rd_tok,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import scf_pkg::*;

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    tok_t             mem_reg [Depth];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(Depth));
    assign rd_valid = (count_reg != CNT_W'(0));
    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Depth - 1)) ? PTR_W'(0)
                                                           : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Depth - 1)) ? PTR_W'(0)
                                                           : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

// ===== hw/rtl/scf_back.sv =====
// Back end: turns tokens into output beats, inserting the escape byte,
// through a registered output stage. Depends on scf_pkg, scf_byte_if.
module scf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  scf_pkg::tok_t tok,
    input  logic          tok_valid,
    output logic          tok_ready,
    scf_byte_if.source    pkt
);
    import scf_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       esc_sent_reg, esc_sent_next;
    logic       free;
    logic       send_esc;

    assign free      = !out_valid_reg || pkt.ready;
    assign send_esc  = tok.esc && !esc_sent_reg;
    assign tok_ready = free && !send_esc;

    assign pkt.valid    = out_valid_reg;
    assign pkt.out_byte = out_byte_reg;
    assign pkt.is_last  = out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        esc_sent_next  = esc_sent_reg;
        if (free)
        begin
            out_valid_next = tok_valid;
            if (tok_valid)
            begin
                if (send_esc)
                begin
                    // hold the token, send the escape first
                    out_byte_next = ESCAPE_BYTE;
                    out_last_next = 1'b0;
                    esc_sent_next = 1'b1;
                end
                else
                begin
                    out_byte_next = tok.data;
                    out_last_next = tok.last;
                    esc_sent_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            esc_sent_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            esc_sent_reg  <= esc_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== hw/rtl/speed_command_framer.sv =====
// Speed command framer: one command in, a flag-framed byte run out.
// The first byte passes the front-end sequencing registers, the token queue and the output register.
// Throughput: one byte per cycle while pkt.ready stays high, set by the single output
// byte port; a command makes 16 to 28 output beats (escapes add one beat each).
// Reset: asynchronous, clears handshake and sequencing state; no clearing pass.
// Depends on scf_pkg, scf_cmd_if, scf_byte_if, scf_front, scf_queue, scf_back.
module speed_command_framer #(
    parameter int QUEUE_DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    scf_cmd_if.sink    cmd,
    scf_byte_if.source pkt
);
    import scf_pkg::*;

    tok_t front_tok, back_tok;
    logic front_valid, front_ready;
    logic back_valid, back_ready;

    scf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .tok       (front_tok),
        .tok_valid (front_valid),
        .tok_ready (front_ready)
    );

    scf_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_tok   (front_tok),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_tok   (back_tok),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    scf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (back_tok),
        .tok_valid (back_valid),
        .tok_ready (back_ready),
        .pkt       (pkt)
    );

endmodule

// ===== verif/speed_command_framer_tb.sv =====
// Testbench for speed_command_framer: drives speed commands, checks the framed byte run.
// A directed table comes first, then biased random commands; each byte is checked in order.
// Depends on scf_pkg, scf_cmd_if, scf_byte_if and the framer RTL.
`timescale 1ns / 1ps

module speed_command_framer_tb;

    import scf_pkg::*;

    typedef struct packed {
        logic [7:0]  robot_id;
        logic [31:0] speed_x;
        logic [31:0] speed_y;
        logic [31:0] turn_rate;
    } speed_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        speed_cmd_t   cmd;
        logic [4:0]   fixed_len;
        logic [223:0] fixed_frame;
    } directed_row_t;

    localparam int DIRECTED_ROWS    = 14;
    localparam int RANDOM_ITEMS     = 116;
    localparam int CALM_TAIL        = 30;
    localparam int HOLD_AT_ITEM     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 50;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 5'd16,
          {128'h7E0001_00000000_00000000_00000000_7E, 96'h0}},
        '{'{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 5'd16,
          {128'h7EFF01_FFFFFFFF_FFFFFFFF_FFFFFFFF_7E, 96'h0}},
        '{'{8'h7E, 32'h7E7E_7E7E, 32'h7E7E_7E7E, 32'h7E7E_7E7E}, 5'd28,
          224'h7E7E01_7D7E7D7E7D7E7D7E_7D7E7D7E7D7E7D7E_7D7E7D7E7D7E7D7E_7E},
        '{'{8'h7D, 32'h7D7D_7D7D, 32'h7D7D_7D7D, 32'h7D7D_7D7D}, 5'd28,
          224'h7E7D01_7D7D7D7D7D7D7D7D_7D7D7D7D7D7D7D7D_7D7D7D7D7D7D7D7D_7E},
        '{'{8'h01, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000}, 5'd0, 224'h0},
        '{'{8'h2A, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000}, 5'd0, 224'h0},
        '{'{8'h55, 32'h0000_0001, 32'h807F_FFFF, 32'h0040_0000}, 5'd0, 224'h0},
        '{'{8'h10, 32'h7E7D_7E7D, 32'h7D00_007E, 32'h007E_7D00}, 5'd0, 224'h0},
        '{'{8'h7E, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C}, 5'd0, 224'h0},
        '{'{8'h7D, 32'h7E00_0000, 32'h0000_007D, 32'h7D7E_0000}, 5'd0, 224'h0},
        '{'{8'hAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF}, 5'd0, 224'h0},
        '{'{8'h80, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0101_0101}, 5'd0, 224'h0},
        '{'{8'h7C, 32'h7C7F_7F7C, 32'hFE7E_FD7D, 32'h7F7E_7D7C}, 5'd0, 224'h0},
        '{'{8'h7F, 32'hC2F6_E97D, 32'h437E_0000, 32'hBE7D_7E01}, 5'd0, 224'h0}
    };

    logic clk;
    logic rst_n;

    scf_cmd_if  cmd_ch ();
    scf_byte_if pkt_ch ();

    speed_command_framer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pkt   (pkt_ch)
    );

    frame_byte_t pending_frame_bytes [$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          idle_on    = 1'b1;

    function automatic void frame_command(input speed_cmd_t c);
        logic [31:0] words [3];
        logic [7:0]  b;
        words[0] = c.speed_x;
        words[1] = c.speed_y;
        words[2] = c.turn_rate;
        pending_frame_bytes.push_back('{FLAG_BYTE, 1'b0});
        pending_frame_bytes.push_back('{c.robot_id, 1'b0});
        pending_frame_bytes.push_back('{SPEED_CODE, 1'b0});
        foreach (words[w])
        begin
            for (int k = 0; k < VALUE_BYTES; k++)
            begin
                b = words[w][8*k +: 8];
                if (b == FLAG_BYTE || b == ESCAPE_BYTE)
                    pending_frame_bytes.push_back('{ESCAPE_BYTE, 1'b0});
                pending_frame_bytes.push_back('{b, 1'b0});
            end
        end
        pending_frame_bytes.push_back('{FLAG_BYTE, 1'b1});
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] word;
        int          pick;
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        for (int k = 0; k < VALUE_BYTES; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                word[8*k +: 8] = FLAG_BYTE;
            else if (pick < 40)
                word[8*k +: 8] = ESCAPE_BYTE;
            else if (pick < 48)
                word[8*k +: 8] = ($urandom_range(0, 1) == 0) ? 8'h7C : 8'h7F;
            else
                word[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return word;
    endfunction

    task automatic send_command(input speed_cmd_t c, input logic [4:0] fixed_len,
                                input logic [223:0] fixed_frame);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.robot_id       <= c.robot_id;
        cmd_ch.speed_x_bits   <= c.speed_x;
        cmd_ch.speed_y_bits   <= c.speed_y;
        cmd_ch.turn_rate_bits <= c.turn_rate;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (fixed_len != 0)
        begin
            for (int i = 0; i < fixed_len; i++)
                pending_frame_bytes.push_back('{fixed_frame[223 - 8*i -: 8],
                                                i == fixed_len - 1});
        end
        else
            frame_command(c);
        items_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        speed_cmd_t c;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.robot_id       <= 8'h00;
        cmd_ch.speed_x_bits   <= 32'h0;
        cmd_ch.speed_y_bits   <= 32'h0;
        cmd_ch.turn_rate_bits <= 32'h0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_command(DIRECTED[r].cmd, DIRECTED[r].fixed_len, DIRECTED[r].fixed_frame);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0:       c.robot_id = FLAG_BYTE;
                1:       c.robot_id = ESCAPE_BYTE;
                default: c.robot_id = 8'($urandom_range(0, 255));
            endcase
            c.speed_x   = random_word();
            c.speed_y   = random_word();
            c.turn_rate = random_word();
            send_command(c, 5'd0, 224'h0);
        end
        cmd_ch.valid <= 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // random ready drops, and one long hold so the framer backs up and stalls its input
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        pkt_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= DIRECTED_ROWS + HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                pkt_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                pkt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                pkt_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            if (pending_frame_bytes.size() == 0)
            begin
                $error("out_byte: expected none, actual 8'h%02h", pkt_ch.out_byte);
                mismatches++;
            end
            else
            begin
                want = pending_frame_bytes.pop_front();
                if (pkt_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected 8'h%02h, actual 8'h%02h",
                           want.data, pkt_ch.out_byte);
                    mismatches++;
                end
                if (pkt_ch.is_last !== want.last)
                begin
                    $error("is_last: expected %0b, actual %0b", want.last, pkt_ch.is_last);
                    mismatches++;
                end
            end
        end
    end

endmodule

// ===== speed_command_framer.f =====
hw/rtl/scf_pkg.sv
hw/rtl/scf_cmd_if.sv
hw/rtl/scf_byte_if.sv
hw/rtl/scf_front.sv
hw/rtl/scf_queue.sv
hw/rtl/scf_back.sv
hw/rtl/speed_command_framer.sv
verif/speed_command_framer_tb.sv
